// File: src/fsr_pkg.sv
package fsr_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] HEAD_ONE    = 8'hFA;
  localparam logic [BYTE_W-1:0] HEAD_TWO    = 8'hAA;
  localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd5;
  localparam logic [BYTE_W-1:0] STATION_RST = 8'd1;

  // header byte positions
  localparam int POS_HEAD_ONE = 0;
  localparam int POS_HEAD_TWO = 1;
  localparam int POS_STATION  = 2;
  localparam int POS_LENGTH   = 3;
  localparam int POS_PAYLOAD  = 4;

endpackage

// File: src/stuffed_frame_receiver.sv
// A header or mid-frame byte gives no result; the checksum byte's error result
// comes in the next cycle. A good frame is read back from the frame RAM one
// payload byte at a time (read, then evaluate). Throughput: one byte per cycle
// while receiving (not at a checksum byte while an output is pending); input
// stalls in readout. Reset: synchronous, active low; clears hunt; station id 1.
module stuffed_frame_receiver #(
  parameter int MAX_FRAME = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fsr_pkg::BYTE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fsr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fsr_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                       out_byte_valid,
  output logic                       out_last_of_frame,
  output logic                       out_frame_status
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam logic [fsr_pkg::BYTE_W-1:0] MAX_LEN = fsr_pkg::BYTE_W'(MAX_FRAME);

  typedef enum logic [1:0] {
    ST_RX,
    ST_RD,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [PW-1:0]              len_r, len_nxt;
  logic [fsr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [fsr_pkg::BYTE_W-1:0] station_r, station_nxt;
  logic [PW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [fsr_pkg::BYTE_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [fsr_pkg::BYTE_W-1:0] pend_r, pend_nxt;
  logic                       pend_vld_r, pend_vld_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [fsr_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                       out_bv_r, out_bv_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_stat_r, out_stat_nxt;

  logic                       in_fire, out_free, at_final, hdr_ok, drop, kept;
  logic                       ram_wr_en, ram_rd_en;
  logic [fsr_pkg::BYTE_W-1:0] rd_data;
  logic [PW-1:0]              pos_inc;

  assign pos_inc  = pos_r + PW'(1);
  assign at_final = (pos_r >= PW'(fsr_pkg::POS_PAYLOAD)) && (pos_inc >= len_r);
  assign in_stall = (state_r != ST_RX) || (out_valid_r && at_final);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (pos_r)
      PW'(fsr_pkg::POS_HEAD_ONE): hdr_ok = (in_rx_byte == fsr_pkg::HEAD_ONE);
      PW'(fsr_pkg::POS_HEAD_TWO): hdr_ok = (in_rx_byte == fsr_pkg::HEAD_TWO);
      PW'(fsr_pkg::POS_STATION):  hdr_ok = (in_rx_byte == station_r);
      PW'(fsr_pkg::POS_LENGTH):
        hdr_ok = (in_rx_byte >= fsr_pkg::MIN_LENGTH) && (in_rx_byte <= MAX_LEN);
      default:                    hdr_ok = 1'b1;
    endcase
  end

  assign drop = (rd_data == fsr_pkg::STUFF_BYTE) && (p1_r == fsr_pkg::HEAD_TWO) &&
                (p2_r == fsr_pkg::HEAD_ONE);
  assign kept = !drop;

  assign ram_wr_en = in_fire && hdr_ok && !at_final;
  assign ram_rd_en = (state_r == ST_RD);

  fsr_frame_ram #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    station_nxt   = cfg_wr_en ? cfg_wr_data : station_r;
    rd_idx_nxt    = rd_idx_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;

    case (state_r)
      ST_RX: begin
        if (in_fire) begin
          if (!hdr_ok) begin
            pos_nxt = '0;
            len_nxt = '0;
            sum_nxt = '0;
          end else if (!at_final) begin
            if (pos_r == PW'(fsr_pkg::POS_LENGTH)) begin
              len_nxt = in_rx_byte[PW-1:0];
            end
            sum_nxt = sum_r + in_rx_byte;
            pos_nxt = pos_inc;
          end else begin
            pos_nxt = '0;
            sum_nxt = '0;
            if (sum_r != in_rx_byte) begin
              // checksum error: single error transfer
              len_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_bv_nxt    = 1'b0;
              out_last_nxt  = 1'b1;
              out_stat_nxt  = 1'b1;
            end else begin
              rd_idx_nxt   = PW'(fsr_pkg::POS_PAYLOAD);
              p1_nxt       = '0;
              p2_nxt       = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = (len_r == PW'(fsr_pkg::MIN_LENGTH)) ? ST_FLUSH : ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // hold a kept byte back one step so the last one can be flagged
        if (drop || !pend_vld_r || out_free) begin
          if (kept && pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
            out_bv_nxt    = 1'b1;
            out_last_nxt  = 1'b0;
            out_stat_nxt  = 1'b0;
          end
          if (kept) begin
            pend_nxt     = rd_data;
            pend_vld_nxt = 1'b1;
          end
          p2_nxt     = p1_r;
          p1_nxt     = rd_data;
          rd_idx_nxt = rd_idx_r + PW'(1);
          state_nxt  = (rd_idx_r + PW'(2) == len_r) ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_vld_r ? pend_r : '0;
          out_bv_nxt    = pend_vld_r;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = 1'b0;
          len_nxt       = '0;
          state_nxt     = ST_RX;
        end
      end
      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      pos_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      station_r   <= fsr_pkg::STATION_RST;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
      station_r   <= station_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_data_r;
  assign out_byte_valid    = out_bv_r;
  assign out_last_of_frame = out_last_r;
  assign out_frame_status  = out_stat_r;

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status |-> !out_byte_valid && out_last_of_frame)
    else $error("checksum error transfer carries data or is not last");

  a_last_back_to_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_of_frame |-> state_r == ST_RX)
    else $error("final transfer while readout still running");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> (rd_idx_r + PW'(2) <= len_r) &&
                           (rd_idx_r >= PW'(fsr_pkg::POS_PAYLOAD)))
    else $error("readout index outside payload");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_RX |-> !ram_wr_en)
    else $error("frame RAM written during readout");

endmodule

// File: src/fsr_frame_ram.sv
module fsr_frame_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fsr_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [fsr_pkg::BYTE_W-1:0] rd_data
);

  logic [fsr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [fsr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
